// File: rtl/hsvc_pkg.sv
package hsvc_pkg;

  // Field widths
  localparam int unsigned HUE_W = 16;
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned RGB_W = 16;

  // Hue geometry
  localparam int unsigned HUE_MOD = 360;
  localparam int unsigned SECTOR_DEG = 60;
  localparam int unsigned DEG_W = 9;   // reduced hue, 0..359
  localparam int unsigned OFS_W = 6;   // offset in sector / ramp weight, 0..60

  // Channel scale and rounding denominators
  localparam int unsigned CHAN_MAX = 255;
  localparam int unsigned RAMP_DEN = 15300;  // 60 * 255

  // Intermediate widths
  localparam int unsigned WGT_W = 14;   // s*k + 60*(255-s), at most 15300
  localparam int unsigned LNUM_W = 16;  // v*(255-s)
  localparam int unsigned RNUM_W = 22;  // v*(s*k + 60*(255-s))
  localparam int unsigned LDIV_W = 17;  // 2*lnum + 255
  localparam int unsigned RDIV_W = 23;  // 2*rnum + 15300

  // Number of register stages from input to output register
  localparam int unsigned STAGES = 7;

  // Hue sectors, 60 degrees each
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  // Pack 8-bit channels into RGB565
  function automatic logic [RGB_W-1:0] pack565(input logic [CHAN_W-1:0] r,
                                               input logic [CHAN_W-1:0] g,
                                               input logic [CHAN_W-1:0] b);
    pack565 = {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

// File: rtl/hsvc_const_div.sv
// Floor division by a constant: reciprocal multiply before the register,
// one compare-and-subtract correction after it.
module hsvc_const_div #(
  parameter int unsigned NUM_W = 16,
  parameter int unsigned DEN = 360,
  parameter int unsigned Q_W = 8,
  parameter int unsigned R_W = 9
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  output logic [Q_W-1:0]   quot,
  output logic [R_W-1:0]   rem
);

  localparam int unsigned SH = NUM_W + 1;
  localparam int unsigned PROD_W = NUM_W + SH;
  localparam logic [SH-1:0] RCP = SH'((64'd1 << SH) / DEN);

  logic [PROD_W-1:0] prod;
  logic [Q_W-1:0]    q_r;
  logic [NUM_W-1:0]  num_r;
  logic [NUM_W-1:0]  base;
  logic [NUM_W-1:0]  diff;
  logic              fix;

  // Estimate quotient, low by at most one
  assign prod = PROD_W'(num) * PROD_W'(RCP);

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= prod[SH +: Q_W];
      num_r <= num;
    end
  end

  // Correct the estimate
  assign base = NUM_W'(q_r) * NUM_W'(DEN);
  assign diff = num_r - base;
  assign fix = (diff >= NUM_W'(DEN));
  assign quot = q_r + Q_W'(fix);
  assign rem = fix ? R_W'(diff - NUM_W'(DEN)) : R_W'(diff);

endmodule

// File: rtl/hsv_to_rgb565_convert_top.sv
// HSV to RGB565 converter. Takes one request per clock while in_stall is low
// and returns one RGB565 word per request through seven register stages:
// hue reduction modulo 360 (reciprocal multiply, then correction), sector
// and ramp weight, the weight and zero-channel products, the ramp product,
// and the two round-half-up divisions by 255 and 15300 (reciprocal
// multiply, then correction and packing). Valid bits travel with the data
// and each stage refills as soon as it empties, so bubbles close up while
// the output stalls. Hue values of 360 and above wrap; zero saturation gives
// grey, zero brightness gives black.
module hsv_to_rgb565_convert_top
  import hsvc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [HUE_W-1:0]  in_hue,
  input  logic [CHAN_W-1:0] in_saturation,
  input  logic [CHAN_W-1:0] in_brightness,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [RGB_W-1:0]  out_rgb565
);

  logic [STAGES:1]   vld_r;
  logic [STAGES:1]   vld_nxt;
  logic [STAGES+1:1] rdy;

  // Stage 1: hue reciprocal estimate (inside divider), carry s and v
  logic [CHAN_W-1:0] s1_r, v1_r;
  // Stage 2: reduced hue
  logic [DEG_W-1:0]  h2_r, h2_nxt;
  logic [CHAN_W-1:0] s2_r, v2_r;
  // Stage 3: sector and ramp weight
  sector_t           sec3_r, sec3_nxt;
  logic [OFS_W-1:0]  k3_r, k3_nxt;
  logic [CHAN_W-1:0] s3_r, v3_r;
  // Stage 4: products
  sector_t           sec4_r;
  logic [WGT_W-1:0]  t4_r, t4_nxt;
  logic [LNUM_W-1:0] lnum4_r, lnum4_nxt;
  logic [CHAN_W-1:0] v4_r;
  // Stage 5: rounding dividends
  sector_t           sec5_r;
  logic [RDIV_W-1:0] ry5_r, ry5_nxt;
  logic [LDIV_W-1:0] ly5_r, ly5_nxt;
  logic [CHAN_W-1:0] v5_r;
  logic [RNUM_W-1:0] rnum;
  // Stage 6: quotient estimates (inside dividers)
  sector_t           sec6_r;
  logic [CHAN_W-1:0] v6_r;
  // Stage 7: output
  logic [RGB_W-1:0]  rgb7_r, rgb7_nxt;

  logic [DEG_W-1:0]  hue_rem;
  logic [OFS_W-1:0]  f3;
  logic [DEG_W-1:0]  sec_base;
  logic [CHAN_W-1:0] sinv3;
  logic [CHAN_W-1:0] low_ch, ramp_ch, top_ch;
  logic [CHAN_W-1:0] r_ch, g_ch, b_ch;

  // Ready chain: a stage loads when empty or when its successor loads
  always_comb begin
    rdy[STAGES+1] = !out_stall;
    for (int i = STAGES; i >= 1; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  assign in_stall = !rdy[1];

  // Advance valid bits
  always_comb begin
    vld_nxt = vld_r;
    if (rdy[1]) begin
      vld_nxt[1] = in_valid;
    end
    for (int i = 2; i <= STAGES; i++) begin
      if (rdy[i]) begin
        vld_nxt[i] = vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Stage 1/2: hue modulo 360
  hsvc_const_div #(
    .NUM_W(HUE_W),
    .DEN  (HUE_MOD),
    .Q_W  (8),
    .R_W  (DEG_W)
  ) u_hue_div (
    .clk (clk),
    .en  (rdy[1]),
    .num (in_hue),
    .quot(),
    .rem (hue_rem)
  );

  assign h2_nxt = hue_rem;

  // Stage 3: find sector, offset and ramp weight
  always_comb begin
    if (h2_r >= DEG_W'(5 * SECTOR_DEG)) begin
      sec3_nxt = SEC_MAG_RED;
    end else if (h2_r >= DEG_W'(4 * SECTOR_DEG)) begin
      sec3_nxt = SEC_BLU_MAG;
    end else if (h2_r >= DEG_W'(3 * SECTOR_DEG)) begin
      sec3_nxt = SEC_CYN_BLU;
    end else if (h2_r >= DEG_W'(2 * SECTOR_DEG)) begin
      sec3_nxt = SEC_GRN_CYN;
    end else if (h2_r >= DEG_W'(SECTOR_DEG)) begin
      sec3_nxt = SEC_YEL_GRN;
    end else begin
      sec3_nxt = SEC_RED_YEL;
    end
    case (sec3_nxt)
      SEC_RED_YEL: sec_base = '0;
      SEC_YEL_GRN: sec_base = DEG_W'(SECTOR_DEG);
      SEC_GRN_CYN: sec_base = DEG_W'(2 * SECTOR_DEG);
      SEC_CYN_BLU: sec_base = DEG_W'(3 * SECTOR_DEG);
      SEC_BLU_MAG: sec_base = DEG_W'(4 * SECTOR_DEG);
      default:     sec_base = DEG_W'(5 * SECTOR_DEG);
    endcase
    f3 = OFS_W'(h2_r - sec_base);
    // Odd sectors ramp down
    k3_nxt = sec3_nxt[0] ? (OFS_W'(SECTOR_DEG) - f3) : f3;
  end

  // Stage 4: ramp weight and zero-channel numerator
  assign sinv3 = CHAN_W'(CHAN_MAX) - s3_r;
  assign t4_nxt = WGT_W'(WGT_W'(s3_r) * WGT_W'(k3_r))
                + WGT_W'(WGT_W'(SECTOR_DEG) * WGT_W'(sinv3));
  assign lnum4_nxt = LNUM_W'(v3_r) * LNUM_W'(sinv3);

  // Stage 5: ramp numerator, then dividends for round half up
  assign rnum = RNUM_W'(v4_r) * RNUM_W'(t4_r);
  assign ry5_nxt = {rnum, 1'b0} + RDIV_W'(RAMP_DEN);
  assign ly5_nxt = {lnum4_r, 1'b0} + LDIV_W'(CHAN_MAX);

  // Stage 6/7: rounded channel divisions
  hsvc_const_div #(
    .NUM_W(RDIV_W),
    .DEN  (2 * RAMP_DEN),
    .Q_W  (CHAN_W),
    .R_W  (RDIV_W)
  ) u_ramp_div (
    .clk (clk),
    .en  (rdy[6]),
    .num (ry5_r),
    .quot(ramp_ch),
    .rem ()
  );

  hsvc_const_div #(
    .NUM_W(LDIV_W),
    .DEN  (2 * CHAN_MAX),
    .Q_W  (CHAN_W),
    .R_W  (LDIV_W)
  ) u_low_div (
    .clk (clk),
    .en  (rdy[6]),
    .num (ly5_r),
    .quot(low_ch),
    .rem ()
  );

  // Stage 7: route channels by sector and pack
  assign top_ch = v6_r;

  always_comb begin
    case (sec6_r)
      SEC_RED_YEL: begin r_ch = top_ch;  g_ch = ramp_ch; b_ch = low_ch;  end
      SEC_YEL_GRN: begin r_ch = ramp_ch; g_ch = top_ch;  b_ch = low_ch;  end
      SEC_GRN_CYN: begin r_ch = low_ch;  g_ch = top_ch;  b_ch = ramp_ch; end
      SEC_CYN_BLU: begin r_ch = low_ch;  g_ch = ramp_ch; b_ch = top_ch;  end
      SEC_BLU_MAG: begin r_ch = ramp_ch; g_ch = low_ch;  b_ch = top_ch;  end
      default:     begin r_ch = top_ch;  g_ch = low_ch;  b_ch = ramp_ch; end
    endcase
    rgb7_nxt = pack565(r_ch, g_ch, b_ch);
  end

  // Payload registers, each loads with its stage
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_r <= in_saturation;
      v1_r <= in_brightness;
    end
    if (rdy[2]) begin
      h2_r <= h2_nxt;
      s2_r <= s1_r;
      v2_r <= v1_r;
    end
    if (rdy[3]) begin
      sec3_r <= sec3_nxt;
      k3_r <= k3_nxt;
      s3_r <= s2_r;
      v3_r <= v2_r;
    end
    if (rdy[4]) begin
      sec4_r <= sec3_r;
      t4_r <= t4_nxt;
      lnum4_r <= lnum4_nxt;
      v4_r <= v3_r;
    end
    if (rdy[5]) begin
      sec5_r <= sec4_r;
      ry5_r <= ry5_nxt;
      ly5_r <= ly5_nxt;
      v5_r <= v4_r;
    end
    if (rdy[6]) begin
      sec6_r <= sec5_r;
      v6_r <= v5_r;
    end
    if (rdy[7]) begin
      rgb7_r <= rgb7_nxt;
    end
  end

  assign out_valid = vld_r[STAGES];
  assign out_rgb565 = rgb7_r;

endmodule

// File: rtl/hsvc_check.sv
module hsvc_check
  import hsvc_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic [HUE_W-1:0]  in_hue,
  input logic [CHAN_W-1:0] in_saturation,
  input logic [CHAN_W-1:0] in_brightness,
  input logic              out_valid,
  input logic              out_stall,
  input logic [RGB_W-1:0]  out_rgb565
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rgb565))
    else $error("stalled result changed or dropped");

  // Hold a stalled request
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=>
      in_valid && $stable({in_hue, in_saturation, in_brightness}))
    else $error("stalled request changed or dropped");

  // Drop all results on reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Push back only when the whole pipe is full behind a stalled result
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("request stalled while output side is free");

endmodule

bind hsv_to_rgb565_convert_top hsvc_check u_check (.*);

// File: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top
  import hsvc_pkg::*;
;

  // One color request as it crosses the input channel
  typedef struct packed {
    logic [HUE_W-1:0]  hue;
    logic [CHAN_W-1:0] sat;
    logic [CHAN_W-1:0] bri;
  } hsv_req_t;

  localparam int unsigned RANDOM_REQS = 1950;
  localparam int unsigned PHASE1_END  = 650;
  localparam int unsigned PHASE2_END  = 1300;
  localparam int unsigned HOLD_AT     = 1600;
  localparam int unsigned HOLD_CYCLES = 50;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [HUE_W-1:0]  in_hue = '0;
  logic [CHAN_W-1:0] in_saturation = '0;
  logic [CHAN_W-1:0] in_brightness = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [RGB_W-1:0]  out_rgb565;

  hsv_req_t         color_req_q[$];
  logic [RGB_W-1:0] rgb_expect_q[$];
  int unsigned      reqs_accepted = 0;
  int unsigned      err_count = 0;
  int unsigned      hold_left = 0;
  logic             hold_done = 1'b0;

  hsv_to_rgb565_convert_top u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_brightness (in_brightness),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_rgb565    (out_rgb565)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Expected RGB565 word for one HSV color, exact round half up
  function automatic logic [RGB_W-1:0] hsv_to_565(input hsv_req_t req);
    int unsigned deg, ofs, wgt, s, v;
    sector_t     sec;
    logic [7:0]  top, zero_ch, ramp_ch, red, grn, blu;
    deg = req.hue % HUE_MOD;
    sec = sector_t'(deg / SECTOR_DEG);
    ofs = deg % SECTOR_DEG;
    s = req.sat;
    v = req.bri;
    // ramp falls in odd sectors, rises in even ones
    if (sec[0])
      ofs = SECTOR_DEG - ofs;
    wgt = s * ofs + SECTOR_DEG * (CHAN_MAX - s);
    top = v[7:0];
    zero_ch = 8'((2 * v * (CHAN_MAX - s) + CHAN_MAX) / (2 * CHAN_MAX));
    ramp_ch = 8'((2 * v * wgt + RAMP_DEN) / (2 * RAMP_DEN));
    case (sec)
      SEC_RED_YEL: begin red = top;     grn = ramp_ch; blu = zero_ch; end
      SEC_YEL_GRN: begin red = ramp_ch; grn = top;     blu = zero_ch; end
      SEC_GRN_CYN: begin red = zero_ch; grn = top;     blu = ramp_ch; end
      SEC_CYN_BLU: begin red = zero_ch; grn = ramp_ch; blu = top;     end
      SEC_BLU_MAG: begin red = ramp_ch; grn = zero_ch; blu = top;     end
      default:     begin red = top;     grn = zero_ch; blu = ramp_ch; end
    endcase
    return {red[7:3], grn[7:2], blu[7:3]};
  endfunction

  // Channel value biased toward the ends of the range
  function automatic logic [CHAN_W-1:0] rand_chan();
    case ($urandom_range(9))
      0: return '0;
      1: return 8'd255;
      2: return 8'd1;
      3: return 8'd254;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic hsv_req_t rand_color();
    hsv_req_t req;
    case ($urandom_range(9))
      0, 1, 2, 3: req.hue = 16'($urandom_range(HUE_MOD - 1));
      // straddle a sector boundary
      4, 5: req.hue = 16'(SECTOR_DEG * $urandom_range(1, 6) - 1 + $urandom_range(2));
      6: req.hue = 16'(HUE_MOD * $urandom_range(1, 181) + $urandom_range(HUE_MOD - 1));
      default: req.hue = 16'($urandom_range(65535));
    endcase
    req.sat = rand_chan();
    req.bri = rand_chan();
    return req;
  endfunction

  function automatic int unsigned send_idle_pct(input int unsigned n);
    if (n < PHASE1_END) return 14;
    if (n < PHASE2_END) return 73;
    return 0;
  endfunction

  function automatic int unsigned recv_idle_pct(input int unsigned n);
    if (n < PHASE1_END) return 73;
    if (n < PHASE2_END) return 14;
    return 0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Drive requests; hold the payload while stalled
  always @(posedge clk) begin
    hsv_req_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        rgb_expect_q.push_back(hsv_to_565({in_hue, in_saturation, in_brightness}));
        reqs_accepted <= reqs_accepted + 1;
      end
      if (!in_valid || !in_stall) begin
        if (color_req_q.size() != 0 &&
            $urandom_range(99) >= send_idle_pct(reqs_accepted)) begin
          req = color_req_q.pop_front();
          in_valid <= 1'b1;
          in_hue <= req.hue;
          in_saturation <= req.sat;
          in_brightness <= req.bri;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output stall: random idling plus one long hold to back up the pipeline
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && reqs_accepted >= HOLD_AT) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct(reqs_accepted));
    end
  end

  // Check each returned word against the oldest expectation
  always @(posedge clk) begin
    logic [RGB_W-1:0] exp_rgb;
    if (rst_n && out_valid && !out_stall) begin
      if (rgb_expect_q.size() == 0) begin
        report_mismatch($sformatf("unexpected rgb565 %h", out_rgb565));
      end else begin
        exp_rgb = rgb_expect_q.pop_front();
        if (out_rgb565 !== exp_rgb)
          report_mismatch($sformatf("rgb565 got %h expected %h", out_rgb565, exp_rgb));
      end
    end
  end

  initial begin
    // Directed: primaries, sector edges, hue wrap, grey, black, rounding ties
    color_req_q.push_back('{16'd0,     8'd255, 8'd255});
    color_req_q.push_back('{16'd60,    8'd255, 8'd255});
    color_req_q.push_back('{16'd120,   8'd255, 8'd255});
    color_req_q.push_back('{16'd180,   8'd255, 8'd255});
    color_req_q.push_back('{16'd240,   8'd255, 8'd255});
    color_req_q.push_back('{16'd300,   8'd255, 8'd255});
    color_req_q.push_back('{16'd359,   8'd255, 8'd255});
    color_req_q.push_back('{16'd360,   8'd255, 8'd255});
    color_req_q.push_back('{16'd65535, 8'd255, 8'd255});
    color_req_q.push_back('{16'd30,    8'd255, 8'd255});
    color_req_q.push_back('{16'd90,    8'd255, 8'd255});
    color_req_q.push_back('{16'd200,   8'd0,   8'd200});
    color_req_q.push_back('{16'd65535, 8'd0,   8'd255});
    color_req_q.push_back('{16'd45,    8'd200, 8'd0});
    color_req_q.push_back('{16'd0,     8'd0,   8'd0});
    color_req_q.push_back('{16'd59,    8'd128, 8'd128});
    color_req_q.push_back('{16'd61,    8'd1,   8'd254});
    color_req_q.push_back('{16'd719,   8'd255, 8'd1});
    color_req_q.push_back('{16'd300,   8'd170, 8'd85});
    color_req_q.push_back('{16'd32768, 8'd85,  8'd170});
    color_req_q.push_back('{16'd239,   8'd127, 8'd255});
    color_req_q.push_back('{16'd301,   8'd255, 8'd127});
    for (int i = 0; i < RANDOM_REQS; i++)
      color_req_q.push_back(rand_color());

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Drain input, then outputs, then let the pipeline settle
    while (color_req_q.size() != 0 || in_valid)
      @(posedge clk);
    while (rgb_expect_q.size() != 0)
      @(posedge clk);
    repeat (STAGES * 3) @(posedge clk);

    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: files.f
rtl/hsvc_pkg.sv
rtl/hsvc_const_div.sv
rtl/hsv_to_rgb565_convert_top.sv
rtl/hsvc_check.sv
verif/tb_top.sv
